[hdl/fbpa_pkg.sv]
// Shared types and constants of the fixed block pool allocator.
// Used by the top level and by the shared divider; depends on nothing.

package fbpa_pkg;

    localparam int ADDR_FIELD_W = 32;   // address ports and base register
    localparam int BYTES_W      = 16;   // block_bytes register
    localparam int COUNT_W      = 7;    // block count register and free_blocks
    localparam int SIZE_W       = 17;   // rounded block size, up to 65536
    localparam int TALLY_W      = 32;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 32;

    localparam int DEF_NUM_BLOCKS = 64;
    localparam int DEF_ADDR_WIDTH = 32;

    localparam logic [ADDR_FIELD_W-1:0] RST_BASE  = '0;
    localparam logic [BYTES_W-1:0]      RST_BYTES = 16'd16;
    localparam logic [COUNT_W-1:0]      RST_COUNT = 7'd64;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd2;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_OWNS  = 2'd2,
        OP_INIT  = 2'd3
    } t_op;

    typedef struct packed {
        logic                    start;
        logic [ADDR_FIELD_W-1:0] dividend;
        logic [SIZE_W-1:0]       divisor;
    } t_div_req;

    typedef struct packed {
        logic                    done;
        logic [ADDR_FIELD_W-1:0] quot;
        logic [SIZE_W-1:0]       rem;
    } t_div_rsp;

endpackage

[hdl/fixed_block_pool_allocator_unit.sv]
// Top level of the fixed block pool allocator: control, pool state, free stack and
// in-use map memories. Depends on fbpa_pkg and on the shared divider fbpa_div.
//
// Usage: a command (i_op, i_address) transfers at a rising edge with start high and
// busy low. Each command gives one result, shown for exactly one cycle with o_valid;
// the receiver cannot stall, and the next command may be issued in that cycle.
// The configuration registers are written through i_cfg_we / i_cfg_index / i_cfg_data;
// the user must write them only while the block is idle, which the block does not
// enforce. They take effect only on an initialize command.
// From the accepting edge to the result: initialize passes S_INIT; allocate from the
// never-used blocks passes S_MUL and S_ADD, and reuse of a freed block first passes
// S_POP (free-stack read) and S_MAP (in-use map read); ownership query and free wait
// in S_DIV for the 32-step divider that finds block index and alignment, and free adds
// a map read in S_MAP. Commands are handled one at a time, each after the last is done.
// A free or query below the pool base goes to S_FAIL without using the divider.
// Reset leaves the pool as if initialized from the reset register values (base 0,
// 16-byte blocks, 64 blocks capped at NUM_BLOCKS). No memory clearing pass is needed:
// map entries at or above the never-used mark read as free.

module fixed_block_pool_allocator_unit #(
    parameter int NUM_BLOCKS = fbpa_pkg::DEF_NUM_BLOCKS,
    parameter int ADDR_WIDTH = fbpa_pkg::DEF_ADDR_WIDTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        i_op,
    input  logic [fbpa_pkg::ADDR_FIELD_W-1:0] i_address,
    output logic                              o_valid,
    output logic                              o_ok,
    output logic [fbpa_pkg::ADDR_FIELD_W-1:0] o_block_address,
    output logic [fbpa_pkg::COUNT_W-1:0]      o_free_blocks,
    output logic [fbpa_pkg::TALLY_W-1:0]      o_alloc_total,
    output logic [fbpa_pkg::TALLY_W-1:0]      o_free_total,
    output logic [fbpa_pkg::TALLY_W-1:0]      o_failure_total,
    input  logic                              i_cfg_we,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [fbpa_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import fbpa_pkg::*;

    localparam int IDX_W  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CNT_W  = $clog2(NUM_BLOCKS + 1);
    localparam int CMP_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
    localparam int SUMC_W = CMP_W + 1;
    localparam int PROD_W = IDX_W + SIZE_W;
    localparam int SUM_W  = ADDR_FIELD_W + 1;
    localparam int INIT_W = SIZE_W + COUNT_W;
    localparam logic [64:0] AMASK = (65'd1 << ADDR_WIDTH) - 65'd1;
    localparam int RST_POOL = (int'(RST_COUNT) > NUM_BLOCKS) ? NUM_BLOCKS : int'(RST_COUNT);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FAIL,
        S_INIT,
        S_POP,
        S_MAP,
        S_DIV,
        S_MUL,
        S_ADD
    } t_state;

    // Configuration registers.
    logic [ADDR_FIELD_W-1:0] r_cfg_base;
    logic [BYTES_W-1:0]      r_cfg_bytes;
    logic [COUNT_W-1:0]      r_cfg_count;

    // Control and pool state.
    t_state                  r_state,      n_state;
    t_op                     r_op,         n_op;
    logic [IDX_W-1:0]        r_idx,        n_idx;
    logic                    r_fresh_pick, n_fresh_pick;
    logic [ADDR_FIELD_W-1:0] r_pool_base,  n_pool_base;
    logic [SIZE_W-1:0]       r_pool_size,  n_pool_size;
    logic [COUNT_W-1:0]      r_pool_count, n_pool_count;
    logic [CNT_W-1:0]        r_depth,      n_depth;
    logic [CNT_W-1:0]        r_fresh,      n_fresh;
    logic [CNT_W-1:0]        r_free,       n_free;
    logic [TALLY_W-1:0]      r_alloc_n,    n_alloc_n;
    logic [TALLY_W-1:0]      r_rel_n,      n_rel_n;
    logic [TALLY_W-1:0]      r_fail_n,     n_fail_n;
    logic [PROD_W-1:0]       r_prod,       n_prod;
    logic                    r_valid,      n_valid;
    logic                    r_ok,         n_ok;
    logic [ADDR_FIELD_W-1:0] r_blk,        n_blk;

    // Memories and their ports.
    logic [IDX_W-1:0] stack_mem [NUM_BLOCKS];
    logic             map_mem   [NUM_BLOCKS];
    logic [IDX_W-1:0] r_stack_q;
    logic             r_map_q;
    logic             stack_we, stack_re, map_we, map_re, map_wd;
    logic [IDX_W-1:0] stack_wa, stack_ra, stack_wd, map_wa, map_ra;

    t_div_req div_req;
    t_div_rsp div_rsp;

    // Datapath helpers.
    logic [SIZE_W-1:0]       bytes_sum;
    logic [SIZE_W-1:0]       init_size;
    logic [INIT_W-1:0]       init_prod;
    logic                    init_pass;
    logic                    in_use;
    logic                    pop_have;
    logic                    fresh_avail;
    logic                    located;
    logic                    addr_low;
    logic [ADDR_FIELD_W-1:0] addr_off;
    logic [SUM_W-1:0]        alloc_sum;
    logic [SUM_W-1:0]        alloc_masked;

    assign bytes_sum = {1'b0, r_cfg_bytes} + SIZE_W'(3);
    assign init_size = {bytes_sum[SIZE_W-1:2], 2'b00};
    assign init_prod = INIT_W'(init_size) * INIT_W'(r_cfg_count);
    assign init_pass = (r_cfg_bytes >= BYTES_W'(4)) && (r_cfg_count != '0)
                    && (CMP_W'(r_cfg_count) <= CMP_W'(NUM_BLOCKS))
                    && (65'(init_prod) <= AMASK);

    // Entries at or above the never-used mark have not been written since init.
    assign in_use      = r_map_q && (CMP_W'(r_idx) < CMP_W'(r_fresh));
    assign pop_have    = (CMP_W'(r_idx) < CMP_W'(r_pool_count))
                      && (CMP_W'(r_idx) < CMP_W'(NUM_BLOCKS));
    assign fresh_avail = (CMP_W'(r_fresh) < CMP_W'(r_pool_count))
                      && (CMP_W'(r_fresh) < CMP_W'(NUM_BLOCKS));
    assign located     = (div_rsp.rem == '0)
                      && (div_rsp.quot < ADDR_FIELD_W'(r_pool_count))
                      && (div_rsp.quot < ADDR_FIELD_W'(NUM_BLOCKS));

    assign addr_low     = i_address < r_pool_base;
    assign addr_off     = i_address - r_pool_base;
    assign alloc_sum    = {1'b0, r_pool_base} + SUM_W'(r_prod);
    assign alloc_masked = alloc_sum & AMASK[SUM_W-1:0];

    fbpa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_idx        = r_idx;
        n_fresh_pick = r_fresh_pick;
        n_pool_base  = r_pool_base;
        n_pool_size  = r_pool_size;
        n_pool_count = r_pool_count;
        n_depth      = r_depth;
        n_fresh      = r_fresh;
        n_free       = r_free;
        n_alloc_n    = r_alloc_n;
        n_rel_n      = r_rel_n;
        n_fail_n     = r_fail_n;
        n_prod       = r_prod;
        n_valid      = 1'b0;
        n_ok         = 1'b0;
        n_blk        = '0;
        stack_we     = 1'b0;
        stack_wa     = IDX_W'(r_depth);
        stack_wd     = r_idx;
        stack_re     = 1'b0;
        stack_ra     = IDX_W'(r_depth - CNT_W'(1));
        map_we       = 1'b0;
        map_wa       = r_idx;
        map_wd       = 1'b0;
        map_re       = 1'b0;
        map_ra       = r_stack_q;
        div_req.start    = 1'b0;
        div_req.dividend = addr_off;
        div_req.divisor  = r_pool_size;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op = t_op'(i_op);
                    case (t_op'(i_op))
                        OP_ALLOC: begin
                            if (r_depth != '0) begin
                                stack_re = 1'b1;
                                n_state  = S_POP;
                            end else if (fresh_avail) begin
                                n_idx        = IDX_W'(r_fresh);
                                n_fresh_pick = 1'b1;
                                n_state      = S_MUL;
                            end else begin
                                n_state = S_FAIL;
                            end
                        end
                        OP_FREE, OP_OWNS: begin
                            if (addr_low) begin
                                n_state = S_FAIL;
                            end else begin
                                div_req.start = 1'b1;
                                n_state       = S_DIV;
                            end
                        end
                        OP_INIT: n_state = S_INIT;
                        default: n_state = S_FAIL;
                    endcase
                end
            end
            S_FAIL: begin
                n_valid = 1'b1;
                if (r_op == OP_ALLOC || r_op == OP_FREE) begin
                    n_fail_n = r_fail_n + TALLY_W'(1);
                end
                n_state = S_IDLE;
            end
            S_INIT: begin
                n_valid = 1'b1;
                if (init_pass) begin
                    n_ok         = 1'b1;
                    n_pool_base  = r_cfg_base;
                    n_pool_size  = init_size;
                    n_pool_count = r_cfg_count;
                    n_depth      = '0;
                    n_fresh      = '0;
                    n_free       = CNT_W'(r_cfg_count);
                    n_alloc_n    = '0;
                    n_rel_n      = '0;
                    n_fail_n     = '0;
                end
                n_state = S_IDLE;
            end
            S_POP: begin
                n_idx        = r_stack_q;
                n_fresh_pick = 1'b0;
                map_re       = 1'b1;
                map_ra       = r_stack_q;
                n_state      = S_MAP;
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    if (r_op == OP_OWNS) begin
                        n_valid = 1'b1;
                        n_ok    = located;
                        n_state = S_IDLE;
                    end else if (located) begin
                        n_idx   = div_rsp.quot[IDX_W-1:0];
                        map_re  = 1'b1;
                        map_ra  = div_rsp.quot[IDX_W-1:0];
                        n_state = S_MAP;
                    end else begin
                        n_state = S_FAIL;
                    end
                end
            end
            S_MAP: begin
                if (r_op == OP_ALLOC) begin
                    // The pop is committed whether or not the block can be handed out.
                    n_depth = r_depth - CNT_W'(1);
                    if (pop_have && !in_use) begin
                        n_state = S_MUL;
                    end else begin
                        n_state = S_FAIL;
                    end
                end else if (in_use && (r_depth < CNT_W'(NUM_BLOCKS))) begin
                    map_we   = 1'b1;
                    map_wd   = 1'b0;
                    stack_we = 1'b1;
                    n_depth  = r_depth + CNT_W'(1);
                    n_free   = r_free + CNT_W'(1);
                    n_rel_n  = r_rel_n + TALLY_W'(1);
                    n_valid  = 1'b1;
                    n_ok     = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_state = S_FAIL;
                end
            end
            S_MUL: begin
                n_prod  = PROD_W'(r_idx) * PROD_W'(r_pool_size);
                n_state = S_ADD;
            end
            S_ADD: begin
                map_we    = 1'b1;
                map_wd    = 1'b1;
                if (r_fresh_pick) begin
                    n_fresh = r_fresh + CNT_W'(1);
                end
                n_free    = r_free - CNT_W'(1);
                n_alloc_n = r_alloc_n + TALLY_W'(1);
                n_valid   = 1'b1;
                n_ok      = 1'b1;
                n_blk     = alloc_masked[ADDR_FIELD_W-1:0];
                n_state   = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_op         <= OP_ALLOC;
            r_fresh_pick <= 1'b0;
            r_cfg_base   <= RST_BASE;
            r_cfg_bytes  <= RST_BYTES;
            r_cfg_count  <= RST_COUNT;
            r_pool_base  <= RST_BASE;
            r_pool_size  <= SIZE_W'(RST_BYTES);
            r_pool_count <= COUNT_W'(RST_POOL);
            r_depth      <= '0;
            r_fresh      <= '0;
            r_free       <= CNT_W'(RST_POOL);
            r_alloc_n    <= '0;
            r_rel_n      <= '0;
            r_fail_n     <= '0;
            r_valid      <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_op         <= n_op;
            r_fresh_pick <= n_fresh_pick;
            r_pool_base  <= n_pool_base;
            r_pool_size  <= n_pool_size;
            r_pool_count <= n_pool_count;
            r_depth      <= n_depth;
            r_fresh      <= n_fresh;
            r_free       <= n_free;
            r_alloc_n    <= n_alloc_n;
            r_rel_n      <= n_rel_n;
            r_fail_n     <= n_fail_n;
            r_valid      <= n_valid;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_BASE:  r_cfg_base  <= i_cfg_data[ADDR_FIELD_W-1:0];
                    CFG_BYTES: r_cfg_bytes <= i_cfg_data[BYTES_W-1:0];
                    CFG_COUNT: r_cfg_count <= i_cfg_data[COUNT_W-1:0];
                    default: ;
                endcase
            end
        end
        r_idx  <= n_idx;
        r_prod <= n_prod;
        r_ok   <= n_ok;
        r_blk  <= n_blk;
    end

    always_ff @(posedge i_clk) begin
        if (stack_we) begin
            stack_mem[stack_wa] <= stack_wd;
        end
        if (stack_re) begin
            r_stack_q <= stack_mem[stack_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (map_we) begin
            map_mem[map_wa] <= map_wd;
        end
        if (map_re) begin
            r_map_q <= map_mem[map_ra];
        end
    end

    assign busy            = (r_state != S_IDLE);
    assign o_valid         = r_valid;
    assign o_ok            = r_ok;
    assign o_block_address = r_blk;
    assign o_free_blocks   = COUNT_W'(r_free);
    assign o_alloc_total   = r_alloc_n;
    assign o_free_total    = r_rel_n;
    assign o_failure_total = r_fail_n;

    // A result transfer only happens once the command is finished.
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while a command is still in progress");

    // Every accepted command leaves idle, so busy is high in the cycle after acceptance.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not leave idle");

    // Between commands: free blocks = pool - handed-out-ever + returned to stack.
    a_tally: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |->
        (SUMC_W'(r_free) + SUMC_W'(r_fresh) == SUMC_W'(r_pool_count) + SUMC_W'(r_depth)))
        else $error("free count disagrees with stack depth and never-used mark");

    // Only blocks that were handed out can sit on the free stack.
    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= r_fresh)
        else $error("free stack deeper than the number of blocks ever used");

endmodule

[hdl/fbpa_div.sv]
// Restoring divider, one quotient bit per cycle, for the pool offset checks.
// Depends on fbpa_pkg for the request and response structs.

module fbpa_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  fbpa_pkg::t_div_req i_req,
    output fbpa_pkg::t_div_rsp o_rsp
);
    import fbpa_pkg::*;

    localparam int CNT_W = $clog2(ADDR_FIELD_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(ADDR_FIELD_W - 1);

    logic                    r_busy;
    logic                    r_done;
    logic [CNT_W-1:0]        r_cnt;
    logic [ADDR_FIELD_W-1:0] r_quot;
    logic [SIZE_W-1:0]       r_rem;
    logic [SIZE_W-1:0]       r_dsr;

    logic [SIZE_W:0] trial;
    logic [SIZE_W:0] diff;

    assign trial = {r_rem, r_quot[ADDR_FIELD_W-1]};
    assign diff  = trial - {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_quot <= i_req.dividend;
                r_rem  <= '0;
                r_dsr  <= i_req.divisor;
            end else if (r_busy) begin
                // The partial remainder stays below the divisor, so the
                // difference fits in the remainder width whenever it is kept.
                if (!diff[SIZE_W]) begin
                    r_rem  <= diff[SIZE_W-1:0];
                    r_quot <= {r_quot[ADDR_FIELD_W-2:0], 1'b1};
                end else begin
                    r_rem  <= trial[SIZE_W-1:0];
                    r_quot <= {r_quot[ADDR_FIELD_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;
    assign o_rsp.rem  = r_rem;

endmodule
